[sv/assert_macros.svh]
// Assertion macros shared by the debounced input block.
// Depends on nothing; files that assert include it by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property that is switched off while reset is held.
`define DIEEC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked property that also holds during reset.
`define DIEEC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DIEEC_ASSERT(label, clk, rst_n, prop, msg)
`define DIEEC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[sv/dieec_pkg.sv]
// Package for the debounced input block: payload types, codes and sizes.
// Used by every module of the block; depends on nothing.
package dieec_pkg;

    // Number of input channels, each with its own debounce lane.
    localparam int CHANNELS = 32;
    localparam int ENCODERS = CHANNELS / 2;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENC_W    = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

    localparam int CNT_W    = 32;
    localparam int ENC_CNT_W = 16;
    localparam logic [7:0] LIMIT_RESET = 8'd2;

    // Request function codes.
    typedef enum logic [2:0] {
        FUNC_TICK       = 3'd0,
        FUNC_READ_ALL   = 3'd1,
        FUNC_READ_CH    = 3'd2,
        FUNC_READ_CNT   = 3'd3,
        FUNC_RESET_CNT  = 3'd4,
        FUNC_RESET_ALL  = 3'd5,
        FUNC_READ_ENC   = 3'd6
    } t_func;

    // Response status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CH   = 2'd1;
    localparam logic [1:0] STATUS_BAD_KIND = 2'd2;

    // Counter kind codes.
    localparam logic [7:0] KIND_FALL = 8'd0;
    localparam logic [7:0] KIND_RISE = 8'd1;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] raw_inputs;
        logic [7:0]  channel;
        logic [7:0]  counter_kind;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic        irq;
    } t_rsp;

    // Per-lane controls driven by the request decode.
    typedef struct packed {
        logic tick;
        logic clr_rise;
        logic clr_fall;
    } t_lane_ctl;

    // Per-lane filtered state, now and after the current request.
    typedef struct packed {
        logic filt;
        logic filt_next;
    } t_lane_stat;

    // True when a channel index addresses an existing channel.
    function automatic logic ch_in_range(logic [7:0] ch);
        return ch < 8'(CHANNELS);
    endfunction

    // True when an encoder index addresses an existing encoder.
    function automatic logic enc_in_range(logic [7:0] ch);
        return ch < 8'(ENCODERS);
    endfunction

endpackage

[sv/dieec_lane.sv]
// One debounce lane: saturating integrator, filtered bit and edge counters.
// Depends on dieec_pkg.
module dieec_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dieec_pkg::t_lane_ctl        i_ctl,
    input  logic                        i_raw,
    input  logic [7:0]                  i_limit,
    output dieec_pkg::t_lane_stat       o_stat,
    output logic [dieec_pkg::CNT_W-1:0] o_rise_cnt,
    output logic [dieec_pkg::CNT_W-1:0] o_fall_cnt
);

    logic [7:0]                  r_integ, n_integ;
    logic                        r_filt, n_filt;
    logic [dieec_pkg::CNT_W-1:0] r_rise_cnt, n_rise_cnt;
    logic [dieec_pkg::CNT_W-1:0] r_fall_cnt, n_fall_cnt;
    logic                        rise, fall;

    // Integrator counts toward the limit while the pin is high, toward zero while low.
    always_comb begin
        n_integ = r_integ;
        if (i_ctl.tick) begin
            if (i_raw) begin
                if (r_integ < i_limit) begin
                    n_integ = r_integ + 8'd1;
                end
            end else if (r_integ != 8'd0) begin
                n_integ = r_integ - 8'd1;
            end
        end
    end

    // Filtered bit sets at the limit and clears at zero.
    always_comb begin
        n_filt = r_filt;
        if (i_ctl.tick) begin
            if (n_integ >= i_limit) begin
                n_filt = 1'b1;
            end else if (n_integ == 8'd0) begin
                n_filt = 1'b0;
            end
        end
    end

    assign rise = n_filt & ~r_filt;
    assign fall = ~n_filt & r_filt;

    // Edge counters wrap; a clear takes precedence.
    always_comb begin
        n_rise_cnt = r_rise_cnt;
        n_fall_cnt = r_fall_cnt;
        if (i_ctl.clr_rise) begin
            n_rise_cnt = '0;
        end else if (rise) begin
            n_rise_cnt = r_rise_cnt + dieec_pkg::CNT_W'(1);
        end
        if (i_ctl.clr_fall) begin
            n_fall_cnt = '0;
        end else if (fall) begin
            n_fall_cnt = r_fall_cnt + dieec_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_filt     <= 1'b0;
            r_rise_cnt <= '0;
            r_fall_cnt <= '0;
        end else begin
            r_integ    <= n_integ;
            r_filt     <= n_filt;
            r_rise_cnt <= n_rise_cnt;
            r_fall_cnt <= n_fall_cnt;
        end
    end

    assign o_stat.filt      = r_filt;
    assign o_stat.filt_next = n_filt;
    assign o_rise_cnt       = r_rise_cnt;
    assign o_fall_cnt       = r_fall_cnt;

endmodule

[sv/dieec_enc.sv]
// One quadrature encoder over a channel pair: clockwise and counterclockwise counts.
// Depends on dieec_pkg.
module dieec_enc (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dieec_pkg::t_lane_stat           i_a,
    input  dieec_pkg::t_lane_stat           i_b,
    output logic [dieec_pkg::ENC_CNT_W-1:0] o_cw,
    output logic [dieec_pkg::ENC_CNT_W-1:0] o_ccw
);

    logic [dieec_pkg::ENC_CNT_W-1:0] r_cw, n_cw;
    logic [dieec_pkg::ENC_CNT_W-1:0] r_ccw, n_ccw;
    logic                            a_rise;

    // A filtered rise on A counts one step; the direction follows B after the tick.
    assign a_rise = i_a.filt_next & ~i_a.filt;

    always_comb begin
        n_cw  = r_cw;
        n_ccw = r_ccw;
        if (a_rise) begin
            if (i_b.filt_next) begin
                n_ccw = r_ccw + dieec_pkg::ENC_CNT_W'(1);
            end else begin
                n_cw = r_cw + dieec_pkg::ENC_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw  <= '0;
            r_ccw <= '0;
        end else begin
            r_cw  <= n_cw;
            r_ccw <= n_ccw;
        end
    end

    assign o_cw  = r_cw;
    assign o_ccw = r_ccw;

endmodule

[sv/dieec_merge.sv]
// Merging stage: selects the lane and encoder values that a request reads.
// Depends on dieec_pkg.
module dieec_merge (
    input  dieec_pkg::t_req                                         i_req,
    input  logic [dieec_pkg::CHANNELS-1:0]                          i_filt,
    input  logic [dieec_pkg::CHANNELS-1:0][dieec_pkg::CNT_W-1:0]    i_rise_cnt,
    input  logic [dieec_pkg::CHANNELS-1:0][dieec_pkg::CNT_W-1:0]    i_fall_cnt,
    input  logic [dieec_pkg::ENCODERS-1:0][dieec_pkg::ENC_CNT_W-1:0] i_cw,
    input  logic [dieec_pkg::ENCODERS-1:0][dieec_pkg::ENC_CNT_W-1:0] i_ccw,
    input  logic                                                    i_irq_next,
    output dieec_pkg::t_rsp                                         o_rsp
);

    logic                          ch_ok;
    logic [dieec_pkg::CH_W-1:0]    ch_idx;
    logic [dieec_pkg::ENC_W-1:0]   enc_idx;

    assign ch_ok   = dieec_pkg::ch_in_range(i_req.channel);
    assign ch_idx  = i_req.channel[dieec_pkg::CH_W-1:0];
    assign enc_idx = i_req.channel[dieec_pkg::ENC_W-1:0];

    // Decode the function and pick the status and data word.
    always_comb begin
        o_rsp.status    = dieec_pkg::STATUS_OK;
        o_rsp.read_data = '0;
        o_rsp.irq       = i_irq_next;
        unique case (dieec_pkg::t_func'(i_req.func))
            dieec_pkg::FUNC_READ_ALL: begin
                o_rsp.read_data = 32'(i_filt);
            end
            dieec_pkg::FUNC_READ_CH: begin
                if (ch_ok) begin
                    o_rsp.read_data = 32'(i_filt[ch_idx]);
                end else begin
                    o_rsp.status = dieec_pkg::STATUS_BAD_CH;
                end
            end
            dieec_pkg::FUNC_READ_CNT: begin
                if (!ch_ok) begin
                    o_rsp.status = dieec_pkg::STATUS_BAD_CH;
                end else if (i_req.counter_kind == dieec_pkg::KIND_FALL) begin
                    o_rsp.read_data = i_fall_cnt[ch_idx];
                end else if (i_req.counter_kind == dieec_pkg::KIND_RISE) begin
                    o_rsp.read_data = i_rise_cnt[ch_idx];
                end else begin
                    o_rsp.status = dieec_pkg::STATUS_BAD_KIND;
                end
            end
            dieec_pkg::FUNC_RESET_CNT: begin
                if (!ch_ok) begin
                    o_rsp.status = dieec_pkg::STATUS_BAD_CH;
                end
            end
            dieec_pkg::FUNC_READ_ENC: begin
                if (dieec_pkg::enc_in_range(i_req.channel)) begin
                    o_rsp.read_data = {i_cw[enc_idx], i_ccw[enc_idx]};
                end else begin
                    o_rsp.status = dieec_pkg::STATUS_BAD_CH;
                end
            end
            default: begin
                // Tick, reset-all and the unused code return no data.
            end
        endcase
    end

endmodule

[sv/debounced_input_edge_encoder_counter.sv]
// Top level of the debounced input block: request decode, lanes, encoders,
// merge and the two-entry response buffer. Depends on dieec_pkg, dieec_lane,
// dieec_enc, dieec_merge and assert_macros.svh.
//
//   Channel    Signals                       Direction  Handshake
//   request    i_valid, o_ready, i_req       in         valid/ready
//   response   o_valid, i_ready, o_rsp       out        valid/ready
//   config     i_cfg_we, i_cfg_data          in         write enable, no wait
//
// All lanes update in parallel at the accepting edge and the response is registered
// there, so one request per cycle is taken while o_ready is high. The response
// leaves from the output register when the output is free.
// A stalled output parks one further response in a skid register; o_ready
// drops only while that register is full.
// Reset (synchronous, active low) clears all lanes, counters, irq and buffers,
// and loads the debounce limit with 2; no clearing pass follows.
`include "assert_macros.svh"

module debounced_input_edge_encoder_counter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dieec_pkg::t_req i_req,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_data,
    output logic            o_valid,
    input  logic            i_ready,
    output dieec_pkg::t_rsp o_rsp
);

    logic [7:0]                                                 r_limit;
    logic                                                       r_irq, n_irq;
    logic                                                       r_out_valid;
    dieec_pkg::t_rsp                                            r_out;
    logic                                                       r_skid_valid;
    dieec_pkg::t_rsp                                            r_skid;

    logic                                                       acc, take;
    logic                                                       is_tick;
    logic                                                       clr_all, clr_one;
    logic [dieec_pkg::CH_W-1:0]                                 ch_idx;
    dieec_pkg::t_lane_ctl  [dieec_pkg::CHANNELS-1:0]            lane_ctl;
    dieec_pkg::t_lane_stat [dieec_pkg::CHANNELS-1:0]            lane_stat;
    logic [dieec_pkg::CHANNELS-1:0]                             filt, filt_next;
    logic [dieec_pkg::CHANNELS-1:0][dieec_pkg::CNT_W-1:0]       rise_cnt, fall_cnt;
    logic [dieec_pkg::ENCODERS-1:0][dieec_pkg::ENC_CNT_W-1:0]   cw, ccw;
    dieec_pkg::t_rsp                                            new_rsp;

    assign acc  = i_valid & o_ready;
    assign take = r_out_valid & i_ready;

    // Debounce limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= dieec_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Request decode into per-lane controls.
    assign is_tick = acc && (i_req.func == dieec_pkg::FUNC_TICK);
    assign clr_all = acc && (i_req.func == dieec_pkg::FUNC_RESET_ALL);
    assign clr_one = acc && (i_req.func == dieec_pkg::FUNC_RESET_CNT)
                     && dieec_pkg::ch_in_range(i_req.channel);
    assign ch_idx  = i_req.channel[dieec_pkg::CH_W-1:0];

    // One debounce lane per channel.
    for (genvar gi = 0; gi < dieec_pkg::CHANNELS; gi++) begin : g_lane
        assign lane_ctl[gi].tick     = is_tick;
        assign lane_ctl[gi].clr_fall = clr_all || (clr_one && ch_idx == dieec_pkg::CH_W'(gi)
                                       && i_req.counter_kind == dieec_pkg::KIND_FALL);
        assign lane_ctl[gi].clr_rise = clr_all || (clr_one && ch_idx == dieec_pkg::CH_W'(gi)
                                       && i_req.counter_kind != dieec_pkg::KIND_FALL);

        dieec_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (lane_ctl[gi]),
            .i_raw      (i_req.raw_inputs[gi]),
            .i_limit    (r_limit),
            .o_stat     (lane_stat[gi]),
            .o_rise_cnt (rise_cnt[gi]),
            .o_fall_cnt (fall_cnt[gi])
        );

        assign filt[gi]      = lane_stat[gi].filt;
        assign filt_next[gi] = lane_stat[gi].filt_next;
    end

    // One encoder per channel pair.
    for (genvar gk = 0; gk < dieec_pkg::ENCODERS; gk++) begin : g_enc
        dieec_enc u_enc (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_a     (lane_stat[2*gk]),
            .i_b     (lane_stat[2*gk+1]),
            .o_cw    (cw[gk]),
            .o_ccw   (ccw[gk])
        );
    end

    // Interrupt flag: set by a tick that changes the filtered state, cleared by read-all.
    always_comb begin
        n_irq = r_irq;
        if (is_tick && (filt_next != filt)) begin
            n_irq = 1'b1;
        end else if (acc && (i_req.func == dieec_pkg::FUNC_READ_ALL)) begin
            n_irq = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq <= 1'b0;
        end else begin
            r_irq <= n_irq;
        end
    end

    dieec_merge u_merge (
        .i_req      (i_req),
        .i_filt     (filt),
        .i_rise_cnt (rise_cnt),
        .i_fall_cnt (fall_cnt),
        .i_cw       (cw),
        .i_ccw      (ccw),
        .i_irq_next (n_irq),
        .o_rsp      (new_rsp)
    );

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= acc;
            end
        end else if (acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= new_rsp;
            end
        end else if (acc) begin
            r_skid <= new_rsp;
        end
    end

    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // The skid entry only fills behind a held output; a filtered change raises irq; no undefined status leaves.
    `DIEEC_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid full with empty output")
    `DIEEC_ASSERT(a_skid_on_stall, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready), "skid filled without a stall")
    `DIEEC_ASSERT(a_irq_on_change, i_clk, i_rst_n, (is_tick && (filt_next != filt)) |=> r_irq, "filtered change did not raise irq")
    `DIEEC_ASSERT(a_status_code, i_clk, i_rst_n, r_out_valid |-> (r_out.status != 2'd3), "undefined status code")

endmodule
